/* design/phi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package phi_pkg;

    localparam int SLOTS           = 2048;
    localparam int PIECES_PER_SLOT = 48;
    localparam int ELEMS           = PIECES_PER_SLOT * 3;
    localparam int HIST_DEPTH      = SLOTS * ELEMS;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int HIST_AW = $clog2(HIST_DEPTH);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam int OUT_DEPTH = 8;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

    localparam logic [1:0] CMD_SAMPLE  = 2'd0;
    localparam logic [1:0] CMD_BLEND   = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    localparam logic [1:0] LVL_NONE = 2'd0;
    localparam logic [1:0] LVL_ONE  = 2'd1;
    localparam logic [1:0] LVL_PAIR = 2'd2;

    localparam logic [7:0]  MAX_GAP_RESET = 8'd8;
    localparam logic [15:0] ANGLE_HALF    = 16'd32768;
    localparam int          FRAC_BITS     = 16;

    typedef struct packed {
        logic [1:0]  level;
        logic        bank;
        logic [31:0] tick;
    } slot_state_t;

    // One queued job for the back end: a history write or a blend.
    typedef struct packed {
        logic               blend;
        logic               ok;
        logic               bank;
        logic [HIST_AW-1:0] addr;
        logic [31:0]        pos;
        logic [15:0]        angle;
        logic [15:0]        weight;
    } work_t;

    typedef struct packed {
        logic        interpolated;
        logic [31:0] pos;
        logic [15:0] angle;
    } result_t;

endpackage

`default_nettype wire

/* design/phi_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module phi_front
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [1:0]           cmd,
    input  wire logic [10:0]          slot_index,
    input  wire logic [7:0]           element_index,
    input  wire logic signed [31:0]   pos_in,
    input  wire logic [15:0]          angle_in,
    input  wire logic                 last_element,
    input  wire logic [31:0]          tick,
    input  wire logic [15:0]          weight,
    input  wire logic                 cfg_wen,
    input  wire logic [7:0]           cfg_wdata,
    input  wire logic                 q_full,
    output logic                      q_push,
    output phi_pkg::work_t            q_data
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [phi_pkg::SLOT_W-1:0]  clear_idx_reg;
    logic [phi_pkg::SLOT_W-1:0]  clear_idx_next;
    logic [7:0]                  max_gap_reg;

    logic [1:0]  cmd_reg;
    logic [10:0] slot_reg;
    logic [7:0]  elem_reg;
    logic [31:0] pos_reg;
    logic [15:0] angle_reg;
    logic        last_reg;
    logic [31:0] tick_reg;
    logic [15:0] weight_reg;

    phi_pkg::slot_state_t st_mem [phi_pkg::SLOTS];
    phi_pkg::slot_state_t st_rd_reg;
    phi_pkg::slot_state_t st_wdata;
    logic                        st_we;
    logic [phi_pkg::SLOT_W-1:0]  st_waddr;

    logic        accept;
    logic        slot_ok;
    logic        elem_ok;
    logic        tick_repeat;
    logic [31:0] gap;
    logic        gap_ok;

    assign accept = push && !full;
    assign full   = (state_reg != ST_IDLE) || q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_idx_reg <= '0;
            max_gap_reg   <= phi_pkg::MAX_GAP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clear_idx_reg <= clear_idx_next;
            if (cfg_wen)
            begin
                max_gap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd;
            slot_reg   <= slot_index;
            elem_reg   <= element_index;
            pos_reg    <= pos_in;
            angle_reg  <= angle_in;
            last_reg   <= last_element;
            tick_reg   <= tick;
            weight_reg <= weight;
            st_rd_reg  <= st_mem[slot_index[phi_pkg::SLOT_W-1:0]];
        end
        if (st_we)
        begin
            st_mem[st_waddr] <= st_wdata;
        end
    end

    always_comb
    begin
        slot_ok     = 32'(slot_reg) < 32'(phi_pkg::SLOTS);
        elem_ok     = 32'(elem_reg) < 32'(phi_pkg::ELEMS);
        tick_repeat = (st_rd_reg.level != phi_pkg::LVL_NONE) && (st_rd_reg.tick == tick_reg);
        gap         = (st_rd_reg.level != phi_pkg::LVL_NONE) ? (tick_reg - st_rd_reg.tick) : '0;
        gap_ok      = (gap != '0) && (gap <= 32'(max_gap_reg));

        state_next     = state_reg;
        clear_idx_next = clear_idx_reg;
        st_we          = 1'b0;
        st_waddr       = slot_reg[phi_pkg::SLOT_W-1:0];
        st_wdata       = '0;
        q_push         = 1'b0;

        q_data.blend  = (cmd_reg == phi_pkg::CMD_BLEND);
        q_data.ok     = slot_ok && elem_ok && st_rd_reg.level[1];
        q_data.bank   = (cmd_reg == phi_pkg::CMD_BLEND) ? st_rd_reg.bank : !st_rd_reg.bank;
        q_data.addr   = phi_pkg::HIST_AW'(slot_reg) * phi_pkg::HIST_AW'(phi_pkg::ELEMS)
                        + phi_pkg::HIST_AW'(elem_reg);
        q_data.pos    = pos_reg;
        q_data.angle  = angle_reg;
        q_data.weight = weight_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                // Walk every slot once after reset so all slots read as empty.
                st_we    = 1'b1;
                st_waddr = clear_idx_reg;
                if (clear_idx_reg == phi_pkg::SLOT_W'(phi_pkg::SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clear_idx_next = clear_idx_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_IDLE;
                case (cmd_reg)
                    phi_pkg::CMD_SAMPLE:
                    begin
                        if (slot_ok && !tick_repeat)
                        begin
                            q_push = elem_ok;
                            if (last_reg)
                            begin
                                st_we          = 1'b1;
                                st_wdata.bank  = !st_rd_reg.bank;
                                st_wdata.tick  = tick_reg;
                                st_wdata.level = gap_ok ? phi_pkg::LVL_PAIR : phi_pkg::LVL_ONE;
                            end
                        end
                    end
                    phi_pkg::CMD_BLEND:
                    begin
                        q_push = 1'b1;
                    end
                    phi_pkg::CMD_RELEASE:
                    begin
                        st_we = slot_ok;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/phi_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module phi_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire phi_pkg::work_t  data_in,
    output logic                 full,
    input  wire logic            pop,
    output phi_pkg::work_t       data_out,
    output logic                 empty
);

    phi_pkg::work_t entry_reg [phi_pkg::QDEPTH];

    logic [phi_pkg::QAW-1:0] wr_ptr_reg;
    logic [phi_pkg::QAW-1:0] rd_ptr_reg;
    logic [phi_pkg::QAW:0]   count_reg;
    logic                    do_push;
    logic                    do_pop;

    assign full     = (count_reg == (phi_pkg::QAW+1)'(phi_pkg::QDEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

`default_nettype wire

/* design/phi_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module phi_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_empty,
    input  wire phi_pkg::work_t  q_data,
    output logic                 q_pop,
    input  wire logic            pop,
    output logic                 empty,
    output logic                 interpolated,
    output logic signed [31:0]   pos_out,
    output logic [15:0]          angle_out
);

    logic [47:0] hist0_mem [phi_pkg::HIST_DEPTH];
    logic [47:0] hist1_mem [phi_pkg::HIST_DEPTH];
    logic [47:0] hist0_rd_reg;
    logic [47:0] hist1_rd_reg;

    logic        s1_valid_reg;
    logic        s1_ok_reg;
    logic        s1_cur_reg;
    logic [15:0] s1_w_reg;

    logic               s2_valid_reg;
    logic               s2_ok_reg;
    logic signed [32:0] s2_dpos_reg;
    logic signed [16:0] s2_dang_reg;
    logic [31:0]        s2_pa_reg;
    logic [15:0]        s2_ta_reg;
    logic [15:0]        s2_w_reg;

    logic               s3_valid_reg;
    logic               s3_ok_reg;
    logic signed [49:0] s3_ppos_reg;
    logic signed [33:0] s3_pang_reg;
    logic [31:0]        s3_pa_reg;
    logic [15:0]        s3_ta_reg;

    phi_pkg::result_t        out_reg [phi_pkg::OUT_DEPTH];
    phi_pkg::result_t        out_head;
    phi_pkg::result_t        s3_result;
    logic [phi_pkg::OUT_AW-1:0] out_wr_reg;
    logic [phi_pkg::OUT_AW-1:0] out_rd_reg;
    logic [phi_pkg::OUT_CW-1:0] out_count_reg;

    logic                       credit;
    logic [phi_pkg::OUT_CW:0]   pending;
    logic                       issue_write;
    logic                       issue_blend;
    logic                       out_pop;
    logic [31:0]                pa;
    logic [31:0]                pb;
    logic [15:0]                ta;
    logic [15:0]                tb;
    logic [15:0]                tdiff;

    // Blends are issued only when the result queue has room for everything in flight.
    assign pending = (phi_pkg::OUT_CW+1)'(out_count_reg)
                     + (phi_pkg::OUT_CW+1)'(s1_valid_reg)
                     + (phi_pkg::OUT_CW+1)'(s2_valid_reg)
                     + (phi_pkg::OUT_CW+1)'(s3_valid_reg);
    assign credit      = pending < (phi_pkg::OUT_CW+1)'(phi_pkg::OUT_DEPTH);
    assign issue_write = !q_empty && !q_data.blend;
    assign issue_blend = !q_empty && q_data.blend && credit;
    assign q_pop       = issue_write || issue_blend;

    always_ff @(posedge clk)
    begin
        if (issue_write && !q_data.bank)
        begin
            hist0_mem[q_data.addr] <= {q_data.pos, q_data.angle};
        end
        if (issue_blend)
        begin
            hist0_rd_reg <= hist0_mem[q_data.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_write && q_data.bank)
        begin
            hist1_mem[q_data.addr] <= {q_data.pos, q_data.angle};
        end
        if (issue_blend)
        begin
            hist1_rd_reg <= hist1_mem[q_data.addr];
        end
    end

    // The current bank holds the newer sample; the other bank the older one.
    always_comb
    begin
        pa    = s1_cur_reg ? hist0_rd_reg[47:16] : hist1_rd_reg[47:16];
        ta    = s1_cur_reg ? hist0_rd_reg[15:0]  : hist1_rd_reg[15:0];
        pb    = s1_cur_reg ? hist1_rd_reg[47:16] : hist0_rd_reg[47:16];
        tb    = s1_cur_reg ? hist1_rd_reg[15:0]  : hist0_rd_reg[15:0];
        tdiff = tb - ta;
    end

    always_comb
    begin
        s3_result.interpolated = s3_ok_reg;
        s3_result.pos   = s3_ok_reg
                          ? s3_pa_reg + s3_ppos_reg[phi_pkg::FRAC_BITS+31:phi_pkg::FRAC_BITS]
                          : '0;
        s3_result.angle = s3_ok_reg
                          ? s3_ta_reg + s3_pang_reg[phi_pkg::FRAC_BITS+15:phi_pkg::FRAC_BITS]
                          : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue_blend;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ok_reg  <= q_data.ok;
        s1_cur_reg <= q_data.bank;
        s1_w_reg   <= q_data.weight;

        s2_ok_reg   <= s1_ok_reg;
        s2_dpos_reg <= $signed({pb[31], pb}) - $signed({pa[31], pa});
        // A difference of exactly half a turn stays positive.
        s2_dang_reg <= (tdiff > phi_pkg::ANGLE_HALF) ? $signed({1'b1, tdiff})
                                                      : $signed({1'b0, tdiff});
        s2_pa_reg   <= pa;
        s2_ta_reg   <= ta;
        s2_w_reg    <= s1_w_reg;

        s3_ok_reg   <= s2_ok_reg;
        s3_ppos_reg <= s2_dpos_reg * $signed({1'b0, s2_w_reg});
        s3_pang_reg <= s2_dang_reg * $signed({1'b0, s2_w_reg});
        s3_pa_reg   <= s2_pa_reg;
        s3_ta_reg   <= s2_ta_reg;
    end

    assign out_pop      = pop && !empty;
    assign empty        = (out_count_reg == '0);
    assign out_head     = out_reg[out_rd_reg];
    assign interpolated = out_head.interpolated;
    assign pos_out      = out_head.pos;
    assign angle_out    = out_head.angle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg    <= '0;
            out_rd_reg    <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            if (s3_valid_reg)
            begin
                out_wr_reg <= out_wr_reg + 1'b1;
            end
            if (out_pop)
            begin
                out_rd_reg <= out_rd_reg + 1'b1;
            end
            if (s3_valid_reg && !out_pop)
            begin
                out_count_reg <= out_count_reg + 1'b1;
            end
            else if (out_pop && !s3_valid_reg)
            begin
                out_count_reg <= out_count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            out_reg[out_wr_reg] <= s3_result;
        end
    end

endmodule

`default_nettype wire

/* design/pose_history_interpolator_unit.sv */
// Intake: no new item is taken until the per-slot state read-modify-write of the last one is done.
// Result path: a blend passes the job queue, the history read with s1, then s2, s3 and the result queue.
// History reads and the multiplies in the back end add no stall between items.
// Reset: asynchronous, active low; afterwards a pass over all 2048 slots clears the slot state, full high.
`timescale 1ns / 1ps
`default_nettype none

module pose_history_interpolator_unit
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [1:0]           cmd,
    input  wire logic [10:0]          slot_index,
    input  wire logic [7:0]           element_index,
    input  wire logic signed [31:0]   pos_in,
    input  wire logic [15:0]          angle_in,
    input  wire logic                 last_element,
    input  wire logic [31:0]          tick,
    input  wire logic [15:0]          weight,
    input  wire logic                 cfg_wen,
    input  wire logic [7:0]           cfg_wdata,
    output logic                      empty,
    input  wire logic                 pop,
    output logic                      interpolated,
    output logic signed [31:0]        pos_out,
    output logic [15:0]               angle_out
);

    phi_pkg::work_t q_in;
    phi_pkg::work_t q_out;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;

    phi_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .cmd           (cmd),
        .slot_index    (slot_index),
        .element_index (element_index),
        .pos_in        (pos_in),
        .angle_in      (angle_in),
        .last_element  (last_element),
        .tick          (tick),
        .weight        (weight),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_in)
    );

    phi_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .data_in  (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .data_out (q_out),
        .empty    (q_empty)
    );

    phi_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (q_out),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .interpolated (interpolated),
        .pos_out      (pos_out),
        .angle_out    (angle_out)
    );

    // The front end works on one item at a time.
    assert property (@(posedge clk) disable iff (!rst_n) (push && !full) |=> full)
        else $error("front end accepted a second item while busy");

    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("job queue written while full");

    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("job queue read while empty");

endmodule

`default_nettype wire
